// ----- rtl/sha1_pkg.sv -----
// Shared types, constants and round functions of the SHA-1 digest core.
package sha1_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned ROUNDS = 80;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_FILL = 6'd56;
  localparam logic [2:0] LAST_WORD = 3'd4;

  // One queued request: a message byte and/or a close.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       carries_byte;
    logic       last_byte;
  } sha1_item_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_OUT   = 5'b10000
  } sha1_state_e;

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] h;
    case (idx)
      3'd0:    h = H0;
      3'd1:    h = H1;
      3'd2:    h = H2;
      3'd3:    h = H3;
      default: h = H4;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

// ----- rtl/sha1_intf.sv -----
// Valid/ready channel interfaces for message requests and digest words.
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       carries_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output carries_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input carries_byte, input last_byte,
                output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        final_word;

  modport source (output valid, output digest_word, output word_index, output final_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input final_word,
                output ready);
endinterface

// ----- rtl/sha1_front.sv -----
// Input stage: registers each request that carries a byte or a close and drops bare requests that do nothing.
module sha1_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  sha1_in_if.sink             in_i,
  output logic                push_valid_o,
  output sha1_pkg::sha1_item_t push_item_o,
  input  logic                push_ready_i
);

  logic                 hold_valid_q, hold_valid_d;
  sha1_pkg::sha1_item_t hold_item_q;
  logic                 take;
  logic                 useful;

  assign in_i.ready = !hold_valid_q || push_ready_i;
  assign take       = in_i.valid && in_i.ready;
  assign useful     = in_i.carries_byte || in_i.last_byte;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (push_ready_i) begin
      hold_valid_d = 1'b0;
    end
    if (take) begin
      hold_valid_d = useful;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && useful) begin
      hold_item_q.data_byte    <= in_i.data_byte;
      hold_item_q.carries_byte <= in_i.carries_byte;
      hold_item_q.last_byte    <= in_i.last_byte;
    end
  end

  assign push_valid_o = hold_valid_q;
  assign push_item_o  = hold_item_q;

endmodule

// ----- rtl/sha1_queue.sv -----
// Short request queue between the input stage and the digest engine.
module sha1_queue #(
  parameter int unsigned Depth = sha1_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  input  sha1_pkg::sha1_item_t push_item_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output sha1_pkg::sha1_item_t pop_item_o,
  input  logic                 pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sha1_pkg::sha1_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- rtl/sha1_back.sv -----
// Digest engine: block assembly, padding, 80-round compression and digest output.
module sha1_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  input  sha1_pkg::sha1_item_t pop_item_i,
  output logic                 pop_ready_o,
  sha1_out_if.source           out_o
);

  sha1_pkg::sha1_state_e state_q, state_d;

  logic [5:0]  fill_q, fill_d;
  logic [23:0] word_q, word_d;
  logic [31:0] win_q [16];
  logic [31:0] win_d [16];
  logic [31:0] rnd_q [5];
  logic [31:0] rnd_d [5];
  logic [31:0] chain_q [5];
  logic [31:0] chain_d [5];
  logic [6:0]  cnt_q, cnt_d;
  logic [60:0] bytes_q, bytes_d;
  logic        closing_q, closing_d;
  logic        sent80_q, sent80_d;
  logic        len_active_q, len_active_d;
  logic [2:0]  len_cnt_q, len_cnt_d;
  logic        pad_done_q, pad_done_d;
  logic [2:0]  idx_q, idx_d;

  logic        ov_q, ov_d;
  logic [31:0] od_word_q;
  logic [2:0]  od_idx_q;
  logic        od_final_q;
  logic        out_load;

  logic        put_en;
  logic [7:0]  put_byte;
  logic        block_full;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  logic [31:0] f_val, k_val, tmp, sched_x, sched;

  assign len_bits = {bytes_q, 3'b000};
  assign len_byte = 8'(len_bits >> {~len_cnt_q, 3'b000});

  assign f_val   = sha1_pkg::round_f(cnt_q, rnd_q[1], rnd_q[2], rnd_q[3]);
  assign k_val   = sha1_pkg::round_k(cnt_q);
  assign tmp     = {rnd_q[0][26:0], rnd_q[0][31:27]} + f_val + rnd_q[4] + k_val + win_q[0];
  assign sched_x = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign sched   = {sched_x[30:0], sched_x[31]};

  assign block_full = put_en && (fill_q == 6'd63);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    word_d       = word_q;
    win_d        = win_q;
    rnd_d        = rnd_q;
    chain_d      = chain_q;
    cnt_d        = cnt_q;
    bytes_d      = bytes_q;
    closing_d    = closing_q;
    sent80_d     = sent80_q;
    len_active_d = len_active_q;
    len_cnt_d    = len_cnt_q;
    pad_done_d   = pad_done_q;
    idx_d        = idx_q;
    pop_ready_o  = 1'b0;
    put_en       = 1'b0;
    put_byte     = 8'h00;
    out_load     = 1'b0;

    case (state_q)
      sha1_pkg::ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          if (pop_item_i.carries_byte) begin
            put_en   = 1'b1;
            put_byte = pop_item_i.data_byte;
            bytes_d  = bytes_q + 1'b1;
          end
          if (pop_item_i.last_byte) begin
            closing_d = 1'b1;
            state_d   = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        put_en = 1'b1;
        if (!sent80_q) begin
          put_byte = sha1_pkg::PAD_BYTE;
          sent80_d = 1'b1;
        end else if (!len_active_q && (fill_q != sha1_pkg::LEN_FILL)) begin
          put_byte = 8'h00;
        end else begin
          put_byte     = len_byte;
          len_active_d = 1'b1;
          len_cnt_d    = len_cnt_q + 1'b1;
          if (len_cnt_q == 3'd7) begin
            pad_done_d = 1'b1;
          end
        end
      end
      sha1_pkg::ST_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[15] = sched;
        rnd_d[4]  = rnd_q[3];
        rnd_d[3]  = rnd_q[2];
        rnd_d[2]  = {rnd_q[1][1:0], rnd_q[1][31:2]};
        rnd_d[1]  = rnd_q[0];
        rnd_d[0]  = tmp;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == 7'(sha1_pkg::ROUNDS - 1)) begin
          state_d = sha1_pkg::ST_ADD;
        end
      end
      sha1_pkg::ST_ADD: begin
        for (int i = 0; i < 5; i++) begin
          chain_d[i] = chain_q[i] + rnd_q[i];
        end
        if (!closing_q) begin
          state_d = sha1_pkg::ST_IDLE;
        end else if (pad_done_q) begin
          state_d = sha1_pkg::ST_OUT;
        end else begin
          state_d = sha1_pkg::ST_PAD;
        end
      end
      sha1_pkg::ST_OUT: begin
        if (!ov_q || out_o.ready) begin
          out_load = 1'b1;
          idx_d    = idx_q + 1'b1;
          if (idx_q == sha1_pkg::LAST_WORD) begin
            idx_d        = '0;
            bytes_d      = '0;
            closing_d    = 1'b0;
            sent80_d     = 1'b0;
            len_active_d = 1'b0;
            len_cnt_d    = '0;
            pad_done_d   = 1'b0;
            for (int i = 0; i < 5; i++) begin
              chain_d[i] = sha1_pkg::init_hash(3'(i));
            end
            state_d = sha1_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sha1_pkg::ST_IDLE;
      end
    endcase

    if (put_en) begin
      fill_d = fill_q + 1'b1;
      word_d = {word_q[15:0], put_byte};
      if (fill_q[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[15] = {word_q, put_byte};
      end
    end
    if (block_full) begin
      state_d = sha1_pkg::ST_ROUND;
      cnt_d   = '0;
      rnd_d   = chain_q;
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (out_o.ready) begin
      ov_d = 1'b0;
    end
    if (out_load) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sha1_pkg::ST_IDLE;
      fill_q       <= '0;
      cnt_q        <= '0;
      bytes_q      <= '0;
      closing_q    <= 1'b0;
      sent80_q     <= 1'b0;
      len_active_q <= 1'b0;
      len_cnt_q    <= '0;
      pad_done_q   <= 1'b0;
      idx_q        <= '0;
      ov_q         <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        chain_q[i] <= sha1_pkg::init_hash(3'(i));
      end
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      cnt_q        <= cnt_d;
      bytes_q      <= bytes_d;
      closing_q    <= closing_d;
      sent80_q     <= sent80_d;
      len_active_q <= len_active_d;
      len_cnt_q    <= len_cnt_d;
      pad_done_q   <= pad_done_d;
      idx_q        <= idx_d;
      ov_q         <= ov_d;
      chain_q      <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    win_q  <= win_d;
    rnd_q  <= rnd_d;
    if (out_load) begin
      od_word_q  <= chain_q[idx_q];
      od_idx_q   <= idx_q;
      od_final_q <= idx_q == sha1_pkg::LAST_WORD;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.digest_word = od_word_q;
  assign out_o.word_index  = od_idx_q;
  assign out_o.final_word  = od_final_q;

  a_out_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (od_idx_q <= sha1_pkg::LAST_WORD) &&
             (od_final_q == (od_idx_q == sha1_pkg::LAST_WORD)))
    else $error("digest word index out of range or final flag mismatch");

  a_round_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1_pkg::ST_ROUND) |-> (cnt_q < 7'(sha1_pkg::ROUNDS)))
    else $error("round counter past last round");

  a_add_after_rounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1_pkg::ST_ADD) |->
      ($past(state_q) == sha1_pkg::ST_ROUND) && ($past(cnt_q) == 7'(sha1_pkg::ROUNDS - 1)))
    else $error("chain update without a full set of rounds");

  a_out_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1_pkg::ST_OUT) |-> (fill_q == 6'd0) && pad_done_q)
    else $error("digest output with an unfinished block");

endmodule

// ----- rtl/sha1_message_digest_core.sv -----
// Top level of the streaming SHA-1 digest core.
// A full 64-byte block runs 80 rounds and one chain update in the single shared
// round unit, which takes no new bytes meanwhile. A close pads one byte per cycle,
// pausing while a full block runs its rounds, up to byte 56 of a block, then 8 length
// bytes, and then gives the five digest words, each held until the receiver takes it.
// Reset: clears control, queue and length count, loads the initial hash; no clearing pass.
module sha1_message_digest_core #(
  parameter int unsigned QueueDepth = sha1_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha1_in_if.sink    in_i,
  sha1_out_if.source out_o
);

  logic                 f_valid, f_ready;
  sha1_pkg::sha1_item_t f_item;
  logic                 q_valid, q_ready;
  sha1_pkg::sha1_item_t q_item;

  sha1_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (f_valid),
    .push_item_o  (f_item),
    .push_ready_i (f_ready)
  );

  sha1_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_item_i  (f_item),
    .push_ready_o (f_ready),
    .pop_valid_o  (q_valid),
    .pop_item_o   (q_item),
    .pop_ready_i  (q_ready)
  );

  sha1_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_valid),
    .pop_item_i  (q_item),
    .pop_ready_o (q_ready),
    .out_o       (out_o)
  );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench of the streaming SHA-1 digest core.
module tb_top;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } digest_exp_t;

  logic clk_i;
  logic rst_ni;

  sha1_in_if  in_if();
  sha1_out_if out_if();

  sha1_message_digest_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  digest_exp_t digest_q[$];
  int unsigned err_cnt;
  bit          pace;
  int unsigned sink_hold;

  logic [31:0] chain_h[5];
  logic [7:0]  blk_bytes[64];
  int unsigned blk_fill;
  logic [63:0] msg_bits;

  always #6 clk_i = ~clk_i;

  function automatic void load_init_hash();
    chain_h[0] = sha1_pkg::H0;
    chain_h[1] = sha1_pkg::H1;
    chain_h[2] = sha1_pkg::H2;
    chain_h[3] = sha1_pkg::H3;
    chain_h[4] = sha1_pkg::H4;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, x, tmp;
    int t;
    for (t = 0; t < 16; t++) begin
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (t = 0; t < 80; t++) begin
      if (t >= 16) begin
        x = w[(t-3) & 15] ^ w[(t-8) & 15] ^ w[(t-14) & 15] ^ w[t & 15];
        w[t & 15] = {x[30:0], x[31]};
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = sha1_pkg::K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1_pkg::K3;
      end
      tmp = {a[26:0], a[31:27]} + f + e + k + w[t & 15];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    blk_bytes[blk_fill] = v;
    blk_fill++;
    if (blk_fill == 64) begin
      sha1_compress();
      blk_fill = 0;
    end
  endfunction

  function automatic void predict_request(input logic [7:0] data, input logic carries,
                                          input logic last);
    logic [63:0] len;
    digest_exp_t exp_word;
    int i;
    if (carries) begin
      absorb_byte(data);
      msg_bits += 64'd8;
    end
    if (last) begin
      len = msg_bits;
      absorb_byte(sha1_pkg::PAD_BYTE);
      while (blk_fill != sha1_pkg::LEN_FILL) absorb_byte(8'h00);
      for (i = 0; i < 8; i++) absorb_byte(len[63-8*i -: 8]);
      for (i = 0; i < 5; i++) begin
        exp_word.digest_word = chain_h[i];
        exp_word.word_index  = i[2:0];
        exp_word.final_word  = (i[2:0] == sha1_pkg::LAST_WORD);
        digest_q.push_back(exp_word);
      end
      load_init_hash();
      blk_fill = 0;
      msg_bits = '0;
    end
  endfunction

  task automatic send_request(input logic [7:0] data, input logic carries, input logic last);
    int unsigned gap;
    gap = pace ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= data;
    in_if.carries_byte <= carries;
    in_if.last_byte    <= last;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    predict_request(data, carries, last);
  endtask

  task automatic drain_digests();
    in_if.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_message(input int unsigned len, input bit close_on_byte);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        send_request(8'($urandom), 1'b0, 1'b0);
      end
      send_request(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
    end
    if (!close_on_byte || len == 0) begin
      send_request(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  task automatic test_directed();
    pace = 1'b1;
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'hA5, 1'b0, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1);
    pace = 1'b0;
    send_request(8'h12, 1'b1, 1'b0);
    send_request(8'h5A, 1'b0, 1'b0);
    send_request(8'h34, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);
    drain_digests();
  endtask

  task automatic test_block_edges();
    pace = 1'b0;
    send_message(56, 1'b0);
    drain_digests();
  endtask

  task automatic test_random();
    int unsigned boundary_len[4];
    int unsigned len;
    int unsigned req_cnt;
    boundary_len = '{55, 57, 63, 64};
    req_cnt = 0;
    while (req_cnt < 50) begin
      pace = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        len = boundary_len[$urandom_range(0, 3)];
      end else begin
        len = $urandom_range(0, 15);
      end
      send_message(len, 1'($urandom_range(0, 1)));
      req_cnt += len + 1;
      if ($urandom_range(0, 3) == 0) drain_digests();
    end
    if (digest_q.size() != 0) drain_digests();
  endtask

  task automatic test_backpressure();
    int unsigned i;
    pace = 1'b0;
    sink_hold = 400;
    for (i = 0; i < 4; i++) send_message(5, 1'b1);
    drain_digests();
  endtask

  initial begin : receiver
    int unsigned stall;
    digest_exp_t exp_word;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (sink_hold != 0) begin
        out_if.ready <= 1'b0;
        repeat (sink_hold) @(posedge clk_i);
        sink_hold = 0;
      end
      stall = pace ? $urandom_range(0, 10) : 0;
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (out_if.valid !== 1'b1) @(posedge clk_i);
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d", $time,
                 out_if.digest_word, out_if.word_index);
        err_cnt++;
      end else begin
        exp_word = digest_q.pop_front();
        if (out_if.digest_word !== exp_word.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $time,
                   exp_word.digest_word, out_if.digest_word);
          err_cnt++;
        end
        if (out_if.word_index !== exp_word.word_index) begin
          $display("%0t: word_index expected %0d actual %0d", $time,
                   exp_word.word_index, out_if.word_index);
          err_cnt++;
        end
        if (out_if.final_word !== exp_word.final_word) begin
          $display("%0t: final_word expected %b actual %b", $time,
                   exp_word.final_word, out_if.final_word);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #2400000;
    $display("FAIL");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    err_cnt = 0;
    pace = 1'b1;
    sink_hold = 0;
    in_if.valid        <= 1'b0;
    in_if.data_byte    <= 8'h00;
    in_if.carries_byte <= 1'b0;
    in_if.last_byte    <= 1'b0;
    load_init_hash();
    blk_fill = 0;
    msg_bits = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_block_edges();
    test_random();
    test_backpressure();
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
